// File: hw/rtl/scalar_kalman_filter_core_defines.svh
// ----------------------------------------------------------------------------
// scalar kalman filter core assertion macros
// shared property wrappers clocked on aclk and gated by reset
// ----------------------------------------------------------------------------
`ifndef SCALAR_KALMAN_FILTER_CORE_DEFINES_SVH
`define SCALAR_KALMAN_FILTER_CORE_DEFINES_SVH

// same-cycle implication
`define SKF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SKF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/skf_pkg.sv
// ----------------------------------------------------------------------------
// skf_pkg
// types and constants of the scalar kalman filter core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package skf_pkg;

    localparam int DATA_W    = 32;
    localparam int GAIN_W    = 16;
    localparam int CFG_IDX_W = 8;
    localparam int ACC_W     = 51;
    localparam int CNT_W     = 5;
    localparam int DIV_STEPS = 16;
    localparam int MUL_STEPS = 17;

    localparam logic [GAIN_W-1:0] GAIN_MAX = 16'hFFFF;
    localparam logic [GAIN_W:0]   GAIN_ONE = 17'h10000;
    localparam logic [ACC_W-1:0]  ROUND_HALF = 51'd32768;

    localparam logic [DATA_W-1:0] RST_PROCESS_NOISE      = 32'd66;
    localparam logic [DATA_W-1:0] RST_MEASUREMENT_NOISE  = 32'd35586;
    localparam logic [DATA_W-1:0] RST_INITIAL_COVARIANCE = 32'd1311;
    localparam logic [DATA_W-1:0] RST_INITIAL_ESTIMATE   = 32'd0;

    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEASUREMENT_NOISE  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_COVARIANCE = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_ESTIMATE   = 8'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRED,
        ST_DIV,
        ST_EST,
        ST_COV,
        ST_FIN
    } skf_state_t;

endpackage

// File: hw/rtl/scalar_kalman_filter_core.sv
// ----------------------------------------------------------------------------
// scalar kalman filter core
// One-dimensional Kalman filter on signed Q16.16 samples. Each accepted
// measurement beat predicts the covariance (P + Q, saturating), forms the
// gain P/(P+R) in Q0.16, moves the held estimate toward the sample and
// shrinks the covariance to (1-gain)*P. One result beat (estimate, gain)
// follows every measurement beat. The divide and both multiplies run through
// one shared 51-bit adder: a 16-step restoring divider for the gain, then two
// 17-step shift-add multiplies. When R is zero the gain saturates to 65535
// and the divide is skipped. m_valid rises once the final step has run;
// s_ready is low from the accepted measurement beat until then and returns
// with m_valid, so a new measurement beat is not accepted before the
// previous one has been worked through. A result waiting on m_ready does not
// block the next measurement beat; only the final step of that next item
// waits until the earlier result is taken. Writing the initial covariance or
// initial estimate register also presets the held state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "scalar_kalman_filter_core_defines.svh"

module scalar_kalman_filter_core
    import skf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [DATA_W-1:0]    s_measurement,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [DATA_W-1:0]    m_estimate,
    output logic [GAIN_W-1:0]    m_gain,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data
);

    skf_state_t          state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [DATA_W-1:0]   q_reg, q_next;
    logic [DATA_W-1:0]   r_reg, r_next;
    logic [DATA_W-1:0]   init_cov_reg, init_cov_next;
    logic [DATA_W-1:0]   init_est_reg, init_est_next;
    logic [DATA_W-1:0]   held_est_reg, held_est_next;
    logic [DATA_W-1:0]   held_cov_reg, held_cov_next;
    logic [DATA_W-1:0]   meas_reg, meas_next;
    logic [DATA_W-1:0]   pp_reg, pp_next;
    logic [DATA_W:0]     denom_reg, denom_next;
    logic [DATA_W:0]     rem_reg, rem_next;
    logic [DATA_W:0]     err_reg, err_next;
    logic [GAIN_W-1:0]   gain_reg, gain_next;
    logic [GAIN_W:0]     mplr_reg, mplr_next;
    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [ACC_W-1:0]    prod_reg, prod_next;
    logic                m_valid_reg, m_valid_next;
    logic [DATA_W-1:0]   m_estimate_reg, m_estimate_next;
    logic [GAIN_W-1:0]   m_gain_reg, m_gain_next;

    logic [ACC_W-1:0]    add_a, add_b, add_sum;
    logic [DATA_W:0]     pp_sum;
    logic [DATA_W-1:0]   pp_sat;
    logic [DATA_W:0]     denom_w;
    logic [ACC_W-1:0]    est_rnd;
    logic [DATA_W+3:0]   est_sum;
    logic [DATA_W-1:0]   est_sat;

    assign s_ready    = (state_reg == ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign m_valid    = m_valid_reg;
    assign m_estimate = m_estimate_reg;
    assign m_gain     = m_gain_reg;

    // shared adder
    assign add_sum = add_a + add_b;

    assign pp_sum  = {1'b0, held_cov_reg} + {1'b0, q_reg};
    assign pp_sat  = pp_sum[DATA_W] ? {DATA_W{1'b1}} : pp_sum[DATA_W-1:0];
    assign denom_w = {1'b0, pp_sat} + {1'b0, r_reg};

    // round to nearest, ties up, then saturate
    assign est_rnd = prod_reg + ROUND_HALF;
    assign est_sum = {{4{held_est_reg[DATA_W-1]}}, held_est_reg}
                   + {est_rnd[ACC_W-1], est_rnd[ACC_W-1:16]};
    assign est_sat = (est_sum[DATA_W+3:DATA_W-1] == 5'b00000 ||
                      est_sum[DATA_W+3:DATA_W-1] == 5'b11111)
                   ? est_sum[DATA_W-1:0]
                   : (est_sum[DATA_W+3] ? {1'b1, {(DATA_W-1){1'b0}}}
                                        : {1'b0, {(DATA_W-1){1'b1}}});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            q_reg        <= RST_PROCESS_NOISE;
            r_reg        <= RST_MEASUREMENT_NOISE;
            init_cov_reg <= RST_INITIAL_COVARIANCE;
            init_est_reg <= RST_INITIAL_ESTIMATE;
            held_cov_reg <= RST_INITIAL_COVARIANCE;
            held_est_reg <= RST_INITIAL_ESTIMATE;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            q_reg        <= q_next;
            r_reg        <= r_next;
            init_cov_reg <= init_cov_next;
            init_est_reg <= init_est_next;
            held_cov_reg <= held_cov_next;
            held_est_reg <= held_est_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        meas_reg       <= meas_next;
        pp_reg         <= pp_next;
        denom_reg      <= denom_next;
        rem_reg        <= rem_next;
        err_reg        <= err_next;
        gain_reg       <= gain_next;
        mplr_reg       <= mplr_next;
        acc_reg        <= acc_next;
        prod_reg       <= prod_next;
        m_estimate_reg <= m_estimate_next;
        m_gain_reg     <= m_gain_next;
    end

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        q_next          = q_reg;
        r_next          = r_reg;
        init_cov_next   = init_cov_reg;
        init_est_next   = init_est_reg;
        held_cov_next   = held_cov_reg;
        held_est_next   = held_est_reg;
        meas_next       = meas_reg;
        pp_next         = pp_reg;
        denom_next      = denom_reg;
        rem_next        = rem_reg;
        err_next        = err_reg;
        gain_next       = gain_reg;
        mplr_next       = mplr_reg;
        acc_next        = acc_reg;
        prod_next       = prod_reg;
        m_valid_next    = m_valid_reg;
        m_estimate_next = m_estimate_reg;
        m_gain_next     = m_gain_reg;
        add_a           = '0;
        add_b           = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    meas_next  = s_measurement;
                    state_next = ST_PRED;
                end
            end
            ST_PRED: begin
                pp_next    = pp_sat;
                denom_next = denom_w;
                rem_next   = {1'b0, pp_sat};
                err_next   = {meas_reg[DATA_W-1], meas_reg}
                           - {held_est_reg[DATA_W-1], held_est_reg};
                cnt_next   = '0;
                acc_next   = '0;
                if (r_reg == '0 || denom_w == '0) begin
                    gain_next  = GAIN_MAX;
                    mplr_next  = {1'b0, GAIN_MAX};
                    state_next = ST_EST;
                end else begin
                    gain_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                add_a = {17'b0, rem_reg, 1'b0};
                add_b = -{18'b0, denom_reg};
                if (!add_sum[ACC_W-1]) begin
                    rem_next  = add_sum[DATA_W:0];
                    gain_next = {gain_reg[GAIN_W-2:0], 1'b1};
                end else begin
                    rem_next  = {rem_reg[DATA_W-1:0], 1'b0};
                    gain_next = {gain_reg[GAIN_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1)) begin
                    mplr_next  = {1'b0, gain_next};
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_EST;
                end
            end
            ST_EST: begin
                add_a     = {acc_reg[ACC_W-2:0], 1'b0};
                add_b     = mplr_reg[GAIN_W]
                          ? {{(ACC_W-DATA_W-1){err_reg[DATA_W]}}, err_reg} : '0;
                acc_next  = add_sum;
                mplr_next = {mplr_reg[GAIN_W-1:0], 1'b0};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MUL_STEPS - 1)) begin
                    prod_next  = add_sum;
                    acc_next   = '0;
                    mplr_next  = GAIN_ONE - {1'b0, gain_reg};
                    cnt_next   = '0;
                    state_next = ST_COV;
                end
            end
            ST_COV: begin
                add_a     = {acc_reg[ACC_W-2:0], 1'b0};
                add_b     = mplr_reg[GAIN_W] ? {{(ACC_W-DATA_W){1'b0}}, pp_reg} : '0;
                acc_next  = add_sum;
                mplr_next = {mplr_reg[GAIN_W-1:0], 1'b0};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MUL_STEPS - 1)) begin
                    cnt_next   = '0;
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    held_est_next   = est_sat;
                    held_cov_next   = acc_reg[DATA_W+15:16];
                    m_estimate_next = est_sat;
                    m_gain_next     = gain_reg;
                    m_valid_next    = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_valid) begin
            case (cfg_index)
                CFG_PROCESS_NOISE: begin
                    q_next = cfg_data;
                end
                CFG_MEASUREMENT_NOISE: begin
                    r_next = cfg_data;
                end
                CFG_INITIAL_COVARIANCE: begin
                    init_cov_next = cfg_data;
                    held_cov_next = cfg_data;
                end
                CFG_INITIAL_ESTIMATE: begin
                    init_est_next = cfg_data;
                    held_est_next = cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    `SKF_ASSERT_NXT(a_busy_after_accept, s_valid && s_ready, !s_ready, "ready after accept")
    `SKF_ASSERT_IMP(a_div_rem_bound, state_reg == ST_DIV, rem_reg < denom_reg, "remainder overrun")
    `SKF_ASSERT_IMP(a_step_bound, state_reg == ST_EST || state_reg == ST_COV,
                    cnt_reg < CNT_W'(MUL_STEPS), "step count overrun")
    `SKF_ASSERT_IMP(a_result_from_fin, $rose(m_valid), $past(state_reg) == ST_FIN,
                    "result outside final step")

endmodule
